[rtl/core/rlp_pkg.sv]
// ----------------------------------------------------------------------------
// rlp_pkg
// Shared constants for the response likelihood product block.
// ----------------------------------------------------------------------------
package rlp_pkg;

  localparam int ITEMS_DEF        = 64;
  localparam int CATEGORIES_DEF   = 8;
  localparam int THETA_POINTS_DEF = 32;
  localparam int GROUPS_DEF       = 4;

  localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;

  localparam logic [5:0] POINTS_RESET = 6'd32;

endpackage

[rtl/core/rlp_ram.sv]
// ----------------------------------------------------------------------------
// rlp_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rlp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/rlp_fmul.sv]
// ----------------------------------------------------------------------------
// rlp_fmul
// Iterative IEEE double multiplier, round to nearest even. Four 27-bit
// partial products, then a normalize loop and a rounding step.
// ----------------------------------------------------------------------------
module rlp_fmul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] result
);

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_MUL   = 4'b0010,
    F_NORM  = 4'b0100,
    F_ROUND = 4'b1000
  } fstate_t;

  fstate_t state;
  logic              sign;
  logic signed [13:0] exp;
  logic [105:0]      prod;
  logic [52:0]       ma;
  logic [52:0]       mb;
  logic [1:0]        step;

  // operand decode
  logic [10:0] ea, eb;
  logic [51:0] fa, fb;
  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  always_comb begin
    ea     = a[62:52];
    eb     = b[62:52];
    fa     = a[51:0];
    fb     = b[51:0];
    a_nan  = (ea == 11'h7FF) && (fa != '0);
    b_nan  = (eb == 11'h7FF) && (fb != '0);
    a_inf  = (ea == 11'h7FF) && (fa == '0);
    b_inf  = (eb == 11'h7FF) && (fb == '0);
    a_zero = (ea == '0) && (fa == '0);
    b_zero = (eb == '0) && (fb == '0);
  end

  // partial product for the current step
  logic [26:0]  op_a, op_b;
  logic [53:0]  pp;
  logic [105:0] pp_sh;
  always_comb begin
    op_a = step[0] ? {1'b0, ma[52:27]} : ma[26:0];
    op_b = step[1] ? {1'b0, mb[52:27]} : mb[26:0];
    pp   = op_a * op_b;
    unique case (step)
      2'd0:    pp_sh = 106'(pp);
      2'd3:    pp_sh = 106'(pp) << 54;
      default: pp_sh = 106'(pp) << 27;
    endcase
  end

  // rounding of the normalized product
  logic        rup;
  logic [53:0] mant;
  logic signed [13:0] fexp;
  always_comb begin
    rup  = prod[52] & ((|prod[51:0]) | prod[53]);
    mant = {1'b0, prod[105:53]} + 54'(rup);
    if (mant[53]) begin
      fexp = exp + 14'sd1;
    end else if (mant[52]) begin
      fexp = exp;
    end else begin
      fexp = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        F_IDLE: begin
          if (start) begin
            sign <= a[63] ^ b[63];
            if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
              result <= rlp_pkg::QNAN_BITS;
              done   <= 1'b1;
            end else if (a_inf || b_inf) begin
              result <= {a[63] ^ b[63], 11'h7FF, 52'b0};
              done   <= 1'b1;
            end else if (a_zero || b_zero) begin
              result <= {a[63] ^ b[63], 63'b0};
              done   <= 1'b1;
            end else begin
              ma    <= {ea != '0, fa};
              mb    <= {eb != '0, fb};
              exp   <= $signed({3'b0, (ea == '0) ? 11'd1 : ea})
                     + $signed({3'b0, (eb == '0) ? 11'd1 : eb}) - 14'sd1022;
              prod  <= '0;
              step  <= '0;
              state <= F_MUL;
            end
          end
        end
        F_MUL: begin
          // accumulate one partial product per cycle
          prod <= prod + pp_sh;
          step <= step + 2'd1;
          if (step == 2'd3) begin
            state <= F_NORM;
          end
        end
        F_NORM: begin
          // shift right into the subnormal range, or left to normalize
          if (exp < 14'sd1) begin
            if (exp < -14'sd110) begin
              prod <= {105'b0, |prod};
              exp  <= 14'sd1;
            end else if (exp <= -14'sd15) begin
              prod <= {16'b0, prod[105:17], |prod[16:0]};
              exp  <= exp + 14'sd16;
            end else begin
              prod <= {1'b0, prod[105:2], |prod[1:0]};
              exp  <= exp + 14'sd1;
            end
          end else if (!prod[105] && exp > 14'sd1) begin
            if (prod[105:90] == '0 && exp > 14'sd16) begin
              prod <= prod << 16;
              exp  <= exp - 14'sd16;
            end else begin
              prod <= prod << 1;
              exp  <= exp - 14'sd1;
            end
          end else begin
            state <= F_ROUND;
          end
        end
        F_ROUND: begin
          if (fexp >= 14'sd2047) begin
            result <= {sign, 11'h7FF, 52'b0};
          end else begin
            result <= {sign, fexp[10:0], mant[53] ? 52'b0 : mant[51:0]};
          end
          done  <= 1'b1;
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/response_likelihood_product_top.sv]
// ----------------------------------------------------------------------------
// response_likelihood_product_top
// Per-subject likelihood at each ability grid point from table probabilities.
// ----------------------------------------------------------------------------
// A table-write request (func 0) is taken and stores its double in the
// probability RAM. A response request (func 1) with responded set updates
// the running product of each grid point in use, one point at a time through
// a single iterative double multiplier. Each point goes through a RAM read, a
// multiplier start, four partial products, a normalize loop and rounding,
// and then the product is picked up. Normalizing shifts by more than one
// place only when an operand or the result is subnormal. A zero, infinite or
// NaN operand is answered straight from the multiplier start, with no partial
// products, normalizing or rounding. A last-item response then sends one
// result per point in use, one per cycle while the output is not stalled,
// and the products return to 1.0. Input stall is high while a response is
// being worked on.
module response_likelihood_product_top #(
  parameter int ITEMS        = rlp_pkg::ITEMS_DEF,
  parameter int CATEGORIES   = rlp_pkg::CATEGORIES_DEF,
  parameter int THETA_POINTS = rlp_pkg::THETA_POINTS_DEF,
  parameter int GROUPS       = rlp_pkg::GROUPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [5:0]  item_index,
  input  logic [2:0]  category,
  input  logic [4:0]  grid_point,
  input  logic [1:0]  group_index,
  input  logic [63:0] prob_value,
  input  logic        responded,
  input  logic        last_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  grid_index,
  output logic [63:0] likelihood,
  output logic        last
);

  localparam int DEPTH = ITEMS * CATEGORIES * THETA_POINTS * GROUPS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = (THETA_POINTS > 1) ? $clog2(THETA_POINTS) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_START = 5'b00100,
    S_WAIT  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state;
  logic [5:0]  points_cfg;
  logic [PW-1:0] pt;
  logic [5:0]  item_q;
  logic [2:0]  cat_q;
  logic [1:0]  grp_q;
  logic        last_q;
  logic [63:0] prod [THETA_POINTS];

  function automatic logic [31:0] tab_addr(input logic [31:0] it, input logic [31:0] c,
                                           input logic [31:0] p, input logic [31:0] g);
    tab_addr = it + 32'(ITEMS) * (c + 32'(CATEGORIES) * (p + 32'(THETA_POINTS) * g));
  endfunction

  // points in use, clamped to one..THETA_POINTS
  logic [6:0] n_used;
  logic       pt_last;
  always_comb begin
    if (points_cfg == '0) begin
      n_used = 7'd1;
    end else if ({1'b0, points_cfg} > 7'(THETA_POINTS)) begin
      n_used = 7'(THETA_POINTS);
    end else begin
      n_used = {1'b0, points_cfg};
    end
    pt_last = (7'(pt) == n_used - 7'd1);
  end

  // request decode
  logic accept, wr_ok, mul_ok;
  always_comb begin
    accept = in_valid && !in_stall;
    wr_ok  = (32'(item_index) < ITEMS) && (32'(category) < CATEGORIES)
          && (32'(grid_point) < THETA_POINTS) && (32'(group_index) < GROUPS);
    mul_ok = responded && (32'(item_index) < ITEMS) && (32'(category) < CATEGORIES)
          && (32'(group_index) < GROUPS);
  end

  // table addresses
  logic [31:0]   waddr_full, raddr_full;
  logic          ram_we;
  logic [63:0]   ram_rdata;
  assign waddr_full = tab_addr(32'(item_index), 32'(category), 32'(grid_point),
                               32'(group_index));
  assign raddr_full = tab_addr(32'(item_q), 32'(cat_q), 32'(pt), 32'(grp_q));
  assign ram_we     = accept && !func && wr_ok;

  rlp_ram #(
    .WIDTH(64),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr_full[AW-1:0]),
    .wdata(prob_value),
    .raddr(raddr_full[AW-1:0]),
    .rdata(ram_rdata)
  );

  // shared multiplier
  logic        mul_start, mul_done;
  logic [63:0] mul_result;
  assign mul_start = (state == S_START);

  rlp_fmul u_fmul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (prod[pt]),
    .b     (ram_rdata),
    .done  (mul_done),
    .result(mul_result)
  );

  assign in_stall = (state != S_IDLE);

  logic out_load;
  assign out_load = (state == S_EMIT) && (!out_valid || !out_stall);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      points_cfg <= rlp_pkg::POINTS_RESET;
    end else if (cfg_write) begin
      points_cfg <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pt    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          pt <= '0;
          if (accept && func) begin
            item_q <= item_index;
            cat_q  <= category;
            grp_q  <= group_index;
            last_q <= last_item;
            if (mul_ok) begin
              state <= S_READ;
            end else if (last_item) begin
              state <= S_EMIT;
            end
          end
        end
        S_READ:  state <= S_START;
        S_START: state <= S_WAIT;
        S_WAIT: begin
          if (mul_done) begin
            if (pt_last) begin
              pt    <= '0;
              state <= last_q ? S_EMIT : S_IDLE;
            end else begin
              pt    <= pt + PW'(1);
              state <= S_READ;
            end
          end
        end
        S_EMIT: begin
          if (out_load) begin
            if (pt_last) begin
              pt    <= '0;
              state <= S_IDLE;
            end else begin
              pt <= pt + PW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // running products: update per point, drop back to 1.0 after the last send
  always_ff @(posedge clk) begin
    if (rst || (out_load && pt_last)) begin
      for (int i = 0; i < THETA_POINTS; i++) begin
        prod[i] <= rlp_pkg::ONE_BITS;
      end
    end else if (state == S_WAIT && mul_done) begin
      prod[pt] <= mul_result;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      grid_index <= 5'(pt);
      likelihood <= prod[pt];
      last       <= pt_last;
    end
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response likelihood product testbench
// Fills the probability table for a pool of item/category/group keys, then
// sends directed and random requests under several grid-point
// settings, with random bursts on the input and random stalls on the output.
// Every emitted likelihood is checked against a predicted product.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic FUNC_WRITE    = 1'b0;
  localparam logic FUNC_RESPONSE = 1'b1;
  localparam int   NUM_KEYS      = 5;
  localparam int   PHASE_COUNT   = 20;
  localparam int   IDLE_LIMIT    = 20000;
  localparam int   SETTLE_CYCLES = 400;

  // Predicts per-point likelihoods and holds them until the block emits them.
  class likelihood_scoreboard;
    logic [63:0] prob_mem [rlp_pkg::THETA_POINTS_DEF*rlp_pkg::CATEGORIES_DEF*
                           rlp_pkg::ITEMS_DEF*rlp_pkg::GROUPS_DEF];
    logic [63:0] products [rlp_pkg::THETA_POINTS_DEF];
    int          points_active;
    logic [4:0]  exp_index [$];
    logic [63:0] exp_lik [$];
    logic        exp_last [$];
    int          errors;
    int          checked;

    function new();
      points_active = rlp_pkg::POINTS_RESET;
      errors = 0;
      checked = 0;
      foreach (prob_mem[i]) prob_mem[i] = 64'h0;
      foreach (products[i]) products[i] = rlp_pkg::ONE_BITS;
    endfunction

    function int mem_addr(logic [5:0] item, logic [2:0] cat, int pt, logic [1:0] grp);
      return item + rlp_pkg::ITEMS_DEF * (cat + rlp_pkg::CATEGORIES_DEF *
             (pt + rlp_pkg::THETA_POINTS_DEF * grp));
    endfunction

    function void set_points(logic [5:0] value);
      points_active = (value == 0) ? 1 :
                      (value > rlp_pkg::THETA_POINTS_DEF) ? rlp_pkg::THETA_POINTS_DEF : value;
    endfunction

    // IEEE double product, with every NaN folded to the canonical quiet NaN.
    function logic [63:0] dmul(logic [63:0] a, logic [63:0] b);
      logic [63:0] r;
      r = $realtobits($bitstoreal(a) * $bitstoreal(b));
      if (r[62:52] == 11'h7FF && r[51:0] != 0) r = rlp_pkg::QNAN_BITS;
      return r;
    endfunction

    function void note_request(logic fn, logic [5:0] item, logic [2:0] cat,
                               logic [4:0] pt, logic [1:0] grp, logic [63:0] prob,
                               logic resp, logic lst);
      if (fn == FUNC_WRITE) begin
        prob_mem[mem_addr(item, cat, pt, grp)] = prob;
        return;
      end
      if (resp)
        for (int t = 0; t < points_active; t++)
          products[t] = dmul(products[t], prob_mem[mem_addr(item, cat, t, grp)]);
      if (lst) begin
        for (int t = 0; t < points_active; t++) begin
          exp_index.push_back(t[4:0]);
          exp_lik.push_back(products[t]);
          exp_last.push_back(t == points_active - 1);
        end
        foreach (products[i]) products[i] = rlp_pkg::ONE_BITS;
      end
    endfunction

    function void check_result(logic [4:0] idx, logic [63:0] lik, logic lst);
      logic [4:0]  e_idx;
      logic [63:0] e_lik;
      logic        e_lst;
      checked++;
      if (exp_index.size() == 0) begin
        $display("%0t: unexpected result grid_index=%0d likelihood=%h last=%b",
                 $time, idx, lik, lst);
        errors++;
        return;
      end
      e_idx = exp_index.pop_front();
      e_lik = exp_lik.pop_front();
      e_lst = exp_last.pop_front();
      if (idx !== e_idx) begin
        $display("%0t: grid_index expected %0d actual %0d", $time, e_idx, idx);
        errors++;
      end
      if (lik !== e_lik) begin
        $display("%0t: likelihood[%0d] expected %h actual %h", $time, e_idx, e_lik, lik);
        errors++;
      end
      if (lst !== e_lst) begin
        $display("%0t: last[%0d] expected %b actual %b", $time, e_idx, e_lst, lst);
        errors++;
      end
    endfunction

    function int pending();
      return exp_index.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [5:0]  cfg_data = 6'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = 1'b0;
  logic [5:0]  item_index = 6'd0;
  logic [2:0]  category = 3'd0;
  logic [4:0]  grid_point = 5'd0;
  logic [1:0]  group_index = 2'd0;
  logic [63:0] prob_value = 64'h0;
  logic        responded = 1'b0;
  logic        last_item = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  grid_index;
  logic [63:0] likelihood;
  logic        last;

  likelihood_scoreboard sb = new();

  logic [5:0] key_item [NUM_KEYS];
  logic [2:0] key_cat  [NUM_KEYS];
  logic [1:0] key_grp  [NUM_KEYS];
  int         burst_left = 0;
  int         requests_sent = 0;
  int         idle_cycles = 0;
  int         stall_left = 0;
  int         stall_mode = 0;

  response_likelihood_product_top dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .item_index(item_index), .category(category),
    .grid_point(grid_point), .group_index(group_index), .prob_value(prob_value),
    .responded(responded), .last_item(last_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .grid_index(grid_index), .likelihood(likelihood), .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Check each accepted result.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(grid_index, likelihood, last);
  end

  // Stall the output: free runs, random stalls and long holds.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(5, 60);
    end
    stall_left--;
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 2) == 0);
      end
      default: begin
        out_stall <= (stall_left > 4);
      end
    endcase
  end

  // Watchdog on cycles with no request or result accepted.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // Mostly probabilities in (0,1], some special doubles, some random patterns.
  function logic [63:0] pick_prob();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80)
      return $realtobits($urandom_range(1, 1000000) / 1000000.0);
    if (sel < 90) begin
      case ($urandom_range(0, 6))
        0: return 64'h0;
        1: return rlp_pkg::ONE_BITS;
        2: return 64'h7FF0_0000_0000_0000;
        3: return 64'h0000_0000_0000_0001;
        4: return 64'hBFE0_0000_0000_0000;
        5: return 64'h7FEF_FFFF_FFFF_FFFF;
        default: return 64'hFFF4_0000_0000_0001;
      endcase
    end
    return {$urandom, $urandom};
  endfunction

  // Send one request; hold valid across a burst, drop it between bursts.
  task send_request(logic fn, logic [5:0] item, logic [2:0] cat, logic [4:0] pt,
                    logic [1:0] grp, logic [63:0] prob, logic resp, logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid    <= 1'b1;
    func        <= fn;
    item_index  <= item;
    category    <= cat;
    grid_point  <= pt;
    group_index <= grp;
    prob_value  <= prob;
    responded   <= resp;
    last_item   <= lst;
    do @(posedge clk); while (in_stall);
    sb.note_request(fn, item, cat, pt, grp, prob, resp, lst);
    requests_sent++;
  endtask

  task send_response(int k, logic resp, logic lst);
    send_request(FUNC_RESPONSE, key_item[k], key_cat[k], 5'($urandom), key_grp[k],
                 {$urandom, $urandom}, resp, lst);
  endtask

  // Drain, let the block settle, then write the grid-point count.
  task set_points(logic [5:0] value);
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_points(value);
  endtask

  task random_phase(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, NUM_KEYS - 1);
      case ($urandom_range(0, 9))
        0: begin
          // refresh one table entry of a known key
          send_request(FUNC_WRITE, key_item[k], key_cat[k], 5'($urandom), key_grp[k],
                       pick_prob(), 1'($urandom), 1'($urandom));
        end
        1: begin
          // skipped response at any address
          send_request(FUNC_RESPONSE, 6'($urandom), 3'($urandom), 5'($urandom),
                       2'($urandom), {$urandom, $urandom}, 1'b0,
                       ($urandom_range(0, 4) == 0));
        end
        default: begin
          send_response(k, 1'b1, ($urandom_range(0, 4) == 0));
        end
      endcase
    end
    send_response($urandom_range(0, NUM_KEYS - 1), 1'b1, 1'b1);
  endtask

  initial begin
    logic [5:0] phase_points [6];
    phase_points = '{6'd1, 6'd0, 6'd17, 6'd63, 6'd32, 6'd1};
    phase_points[5] = 6'($urandom_range(2, 31));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_points(rlp_pkg::POINTS_RESET);

    // Keys with extreme fields first, then random ones.
    key_item[0] = 6'd0;  key_cat[0] = 3'd0; key_grp[0] = 2'd0;
    key_item[1] = 6'd63; key_cat[1] = 3'd7; key_grp[1] = 2'd3;
    key_item[2] = 6'd21; key_cat[2] = 3'd2; key_grp[2] = 2'd1;
    key_item[3] = 6'd42; key_cat[3] = 3'd5; key_grp[3] = 2'd2;
    for (int k = 4; k < NUM_KEYS; k++) begin
      key_item[k] = 6'($urandom);
      key_cat[k]  = 3'($urandom);
      key_grp[k]  = 2'($urandom);
    end

    // Fill every grid point of each key; key 0 holds ones, the rest mixed doubles.
    for (int k = 0; k < NUM_KEYS; k++)
      for (int p = 0; p < rlp_pkg::THETA_POINTS_DEF; p++)
        send_request(FUNC_WRITE, key_item[k], key_cat[k], 5'(p), key_grp[k],
                     (k == 0) ? rlp_pkg::ONE_BITS : pick_prob(), p[0], p[1]);

    // Directed: skipped last item gives all ones, single and chained products.
    send_response(0, 1'b0, 1'b1);
    send_response(1, 1'b1, 1'b1);
    send_response(2, 1'b1, 1'b0);
    send_response(3, 1'b1, 1'b0);
    send_response(1, 1'b0, 1'b0);
    send_response(2, 1'b1, 1'b1);
    send_response(0, 1'b1, 1'b1);
    // A write carrying last_item and responded produces nothing.
    send_request(FUNC_WRITE, 6'd63, 3'd7, 5'd31, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
    send_request(FUNC_WRITE, 6'd63, 3'd7, 5'd31, 2'd3, 64'h3FE0_0000_0000_0000, 1'b1, 1'b1);
    send_response(1, 1'b1, 1'b1);
    random_phase(PHASE_COUNT);

    foreach (phase_points[i]) begin
      set_points(phase_points[i]);
      random_phase(PHASE_COUNT);
    end

    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests over 7 grid-point settings, checked %0d likelihoods.",
             requests_sent, sb.checked);
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
